### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

    // Byte classes found by the front end.
    localparam logic [2:0] CLS_ZERO  = 3'd0;
    localparam logic [2:0] CLS_ASCII = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_CONT  = 3'd5;
    localparam logic [2:0] CLS_BAD   = 3'd6;

    localparam int CP_W        = 21;
    localparam int BITS_W      = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte: its class and the payload bits it contributes.
    typedef struct packed {
        logic [2:0]        kind;
        logic [BITS_W-1:0] bits;
    } u8d_word_t;

    // One decoded result.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
        logic            end_of_text;
    } u8d_result_t;

endpackage
`default_nettype wire

### rtl/u8d_front.sv
// Input stage: accepts raw bytes and classifies them by their top bits.
`default_nettype none
module u8d_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    output logic                   word_valid,
    input  wire logic              word_ready,
    output u8d_pkg::u8d_word_t     word
);
    import u8d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    u8d_word_t word_reg;
    u8d_word_t word_next;
    logic      take;

    assign in_ready   = !valid_reg || word_ready;
    assign take       = in_valid && in_ready;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        word_next.bits = 7'(in_byte);
        if (in_byte == 8'h00)
        begin
            word_next.kind = CLS_ZERO;
        end
        else if (in_byte[7] == 1'b0)
        begin
            word_next.kind = CLS_ASCII;
        end
        else if (in_byte[7:6] == 2'b10)
        begin
            word_next.kind = CLS_CONT;
            word_next.bits = {1'b0, in_byte[5:0]};
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            word_next.kind = CLS_LEAD2;
            word_next.bits = {2'b0, in_byte[4:0]};
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            word_next.kind = CLS_LEAD3;
            word_next.bits = {3'b0, in_byte[3:0]};
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            word_next.kind = CLS_LEAD4;
            word_next.bits = {4'b0, in_byte[2:0]};
        end
        else
        begin
            word_next.kind = CLS_BAD;
        end
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule
`default_nettype wire

### rtl/u8d_queue.sv
// Short queue of classified bytes between the front and back ends.
`default_nettype none
module u8d_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  u8d_pkg::u8d_word_t  push_word,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output u8d_pkg::u8d_word_t  pop_word
);
    import u8d_pkg::*;

    u8d_word_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

### rtl/u8d_back.sv
// Sequence assembler: holds the decode state and the registered result.
`default_nettype none
module u8d_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           word_valid,
    output logic                word_ready,
    input  u8d_pkg::u8d_word_t  word,
    output logic                res_valid,
    input  wire logic           res_ready,
    output u8d_pkg::u8d_result_t res
);
    import u8d_pkg::*;

    logic [1:0]      left_reg;
    logic [1:0]      left_next;
    logic [CP_W-1:0] pv_reg;
    logic [CP_W-1:0] pv_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    u8d_result_t     out_reg;
    u8d_result_t     out_next;
    logic            emit;
    logic            take;
    logic [CP_W-1:0] pv_shift;

    assign word_ready = !out_valid_reg || res_ready;
    assign take       = word_valid && word_ready;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;
    assign pv_shift   = {pv_reg[CP_W-7:0], word.bits[5:0]};

    always_comb
    begin
        left_next = left_reg;
        pv_next   = pv_reg;
        emit      = 1'b0;
        out_next  = '0;
        if (left_reg != 2'd0)
        begin
            if (word.kind == CLS_CONT)
            begin
                left_next = left_reg - 1'b1;
                if (left_reg == 2'd1)
                begin
                    emit                = 1'b1;
                    out_next.code_point = pv_shift;
                    pv_next             = '0;
                end
                else
                begin
                    pv_next = pv_shift;
                end
            end
            else
            begin
                // Anything but a continuation byte aborts the sequence.
                emit                  = 1'b1;
                out_next.bad_sequence = 1'b1;
                left_next             = 2'd0;
                pv_next               = '0;
            end
        end
        else
        begin
            case (word.kind)
                CLS_ZERO:
                begin
                    emit                 = 1'b1;
                    out_next.end_of_text = 1'b1;
                end
                CLS_ASCII:
                begin
                    emit                = 1'b1;
                    out_next.code_point = CP_W'(word.bits);
                end
                CLS_LEAD2:
                begin
                    left_next = 2'd1;
                    pv_next   = CP_W'(word.bits);
                end
                CLS_LEAD3:
                begin
                    left_next = 2'd2;
                    pv_next   = CP_W'(word.bits);
                end
                CLS_LEAD4:
                begin
                    left_next = 2'd3;
                    pv_next   = CP_W'(word.bits);
                end
                default:
                begin
                    emit                  = 1'b1;
                    out_next.bad_sequence = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= 2'd0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                left_reg <= left_next;
                pv_reg   <= pv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

### rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder.
`default_nettype none
// The decoder takes one byte of UTF-8 text per word on the slave stream and
// gives one word per decoded character on the master stream, at a sustained
// rate of one byte per clock. A byte passes a classifying register, a
// two-entry queue and the sequence assembler, whose state is one 2-bit count
// of continuation bytes still expected and a 21-bit partial value; the
// assembler updates this state once for each byte it takes, and that state
// update sets the rate. Lead bytes and continuation bytes that do not finish
// a character give no output word. A zero byte between characters gives code
// point 0 with tlast set. An ill-formed lead byte, a continuation byte where
// none is expected, or a byte that is not a continuation where one is
// expected, gives code point 0 with tuser set; in the last case the byte is
// consumed and the pending sequence is dropped. There are no overlong,
// surrogate or range checks. Output words are held in a register. While one
// waits to be taken the assembler stops, and the queue and the classifying
// register take up at most three more bytes before the slave side stalls.
module utf8_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_axis_tuser,   // [0] bad_sequence
    output logic             m_axis_tlast    // end_of_text
);
    import u8d_pkg::*;

    logic        f_valid;
    logic        f_ready;
    u8d_word_t   f_word;
    logic        q_valid;
    logic        q_ready;
    u8d_word_t   q_word;
    u8d_result_t res;

    // Front end: register and classify each byte.
    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .word_valid (f_valid),
        .word_ready (f_ready),
        .word       (f_word)
    );

    // Decouples the classifier from the assembler so that each can stall alone.
    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    // Back end: the sequence state and the output register.
    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_valid),
        .word_ready (q_ready),
        .word       (q_word),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {3'b000, res.code_point};
    assign m_axis_tuser = res.bad_sequence;
    assign m_axis_tlast = res.end_of_text;

endmodule
`default_nettype wire
